// ----- design/p2s_pkg.sv -----
package p2s_pkg;

	// Field widths of the input and result words.
	localparam int DIST_W    = 16;
	localparam int DIST_FRAC = 12;
	localparam int ANG_W     = 9;
	localparam int COORD_W   = 12;

	// Signed working width for the final offset and clamp.
	localparam int V_W = COORD_W + 1;

	// Configuration register widths and the write port.
	localparam int CX_W      = 7;
	localparam int CY_W      = 6;
	localparam int RANGE_W   = 4;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_RANGE = 2'd2;

	localparam logic [CX_W-1:0]    CENTER_X_RST   = 7'd64;
	localparam logic [CY_W-1:0]    CENTER_Y_RST   = 6'd32;
	localparam logic [RANGE_W-1:0] FULL_RANGE_RST = 4'd4;

	// Default fraction bits of the sine and cosine values.
	localparam int TRIG_FRAC_BITS_DEF = 15;

	// Angle handling: one quadrant spans 90 degrees.
	localparam int QUAD_DEG = 90;
	localparam int REM_W    = 7;
	localparam logic [ANG_W-1:0] FULL_TURN = 9'd360;
	localparam logic [ANG_W-1:0] DEG_90    = 9'd90;
	localparam logic [ANG_W-1:0] DEG_180   = 9'd180;
	localparam logic [ANG_W-1:0] DEG_270   = 9'd270;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	// The scaled coordinate before the range division stays below 2^11.
	localparam int SCALED_W = 11;

	// Reciprocal of the range in Q1.15 (floor), used for the division.
	localparam int RECIP_SHIFT = 15;
	localparam int RECIP_W     = 16;

	// pi/180 in Q0.32.
	localparam longint unsigned DEG_TO_RAD_Q32 = 64'd74961321;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [ANG_W-1:0]  angle_deg;
		logic              last_point;
	} in_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic               last_out;
	} out_word_t;

	// Load enables of the axis pipeline stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	// floor(2^15 / r); a range of zero behaves as one.
	function automatic logic [RECIP_W-1:0] recip(input logic [RANGE_W-1:0] r);
		logic [RECIP_W-1:0] m;
		unique case (r)
			4'd0:    m = 16'd32768;
			4'd1:    m = 16'd32768;
			4'd2:    m = 16'd16384;
			4'd3:    m = 16'd10922;
			4'd4:    m = 16'd8192;
			4'd5:    m = 16'd6553;
			4'd6:    m = 16'd5461;
			4'd7:    m = 16'd4681;
			4'd8:    m = 16'd4096;
			4'd9:    m = 16'd3640;
			4'd10:   m = 16'd3276;
			4'd11:   m = 16'd2978;
			4'd12:   m = 16'd2730;
			4'd13:   m = 16'd2520;
			4'd14:   m = 16'd2340;
			default: m = 16'd2184;
		endcase
		return m;
	endfunction

endpackage

// ----- design/p2s_trig.sv -----
module p2s_trig #(
	parameter int TRIG_FRAC_BITS = p2s_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic [p2s_pkg::REM_W-1:0] rem_deg,
	output logic [TRIG_FRAC_BITS:0]   sin_val,
	output logic [TRIG_FRAC_BITS:0]   cos_val
);
	import p2s_pkg::*;

	localparam int     TW   = TRIG_FRAC_BITS + 1;
	localparam longint HALF = longint'(1) << (29 - TRIG_FRAC_BITS);
	localparam int     RSH  = 30 - TRIG_FRAC_BITS;

	logic [TW-1:0] sin_rom [QUAD_DEG];
	logic [TW-1:0] cos_rom [QUAD_DEG];

	// Constant tables of sine and cosine over one quadrant. Each entry is a
	// Taylor series in Q2.30: every term is the previous one times x^2,
	// divided by its factor pair, and the sum is rounded to the table width.
	for (genvar g = 0; g < QUAD_DEG; g++) begin : g_rom
		localparam longint unsigned X  = (64'(g) * DEG_TO_RAD_Q32 + 64'd2) >> 2;
		localparam longint unsigned X2 = (X * X) >> 30;
		localparam longint unsigned S1 = ((X * X2) >> 30) / 64'd6;
		localparam longint unsigned S2 = ((S1 * X2) >> 30) / 64'd20;
		localparam longint unsigned S3 = ((S2 * X2) >> 30) / 64'd42;
		localparam longint unsigned S4 = ((S3 * X2) >> 30) / 64'd72;
		localparam longint unsigned S5 = ((S4 * X2) >> 30) / 64'd110;
		localparam longint unsigned S6 = ((S5 * X2) >> 30) / 64'd156;
		localparam longint unsigned C0 = 64'd1 << 30;
		localparam longint unsigned C1 = ((C0 * X2) >> 30) / 64'd2;
		localparam longint unsigned C2 = ((C1 * X2) >> 30) / 64'd12;
		localparam longint unsigned C3 = ((C2 * X2) >> 30) / 64'd30;
		localparam longint unsigned C4 = ((C3 * X2) >> 30) / 64'd56;
		localparam longint unsigned C5 = ((C4 * X2) >> 30) / 64'd90;
		localparam longint unsigned C6 = ((C5 * X2) >> 30) / 64'd132;
		localparam longint unsigned C7 = ((C6 * X2) >> 30) / 64'd182;
		localparam longint S_SUM = longint'(X) - longint'(S1) + longint'(S2)
			- longint'(S3) + longint'(S4) - longint'(S5) + longint'(S6);
		localparam longint C_SUM = longint'(C0) - longint'(C1) + longint'(C2)
			- longint'(C3) + longint'(C4) - longint'(C5) + longint'(C6)
			- longint'(C7);
		localparam longint S_POS = (S_SUM < 0) ? longint'(0) : S_SUM;
		localparam longint C_POS = (C_SUM < 0) ? longint'(0) : C_SUM;
		localparam longint SIN_V = (S_POS + HALF) >>> RSH;
		localparam longint COS_V = (C_POS + HALF) >>> RSH;
		assign sin_rom[g] = SIN_V[TW-1:0];
		assign cos_rom[g] = COS_V[TW-1:0];
	end

	// The remainder is always below 90.
	assign sin_val = sin_rom[rem_deg];
	assign cos_val = cos_rom[rem_deg];

endmodule

// ----- design/p2s_axis.sv -----
module p2s_axis #(
	parameter int TRIG_FRAC_BITS = p2s_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  p2s_pkg::stage_en_t            en,
	input  logic [p2s_pkg::DIST_W-1:0]    dist_s1,
	input  logic [TRIG_FRAC_BITS:0]       mag_s1,
	input  logic                          neg_s1,
	input  logic [p2s_pkg::CX_W-1:0]      centre,
	input  logic [p2s_pkg::RANGE_W-1:0]   range,
	output logic [p2s_pkg::COORD_W-1:0]   coord_s6
);
	import p2s_pkg::*;

	localparam int TW     = TRIG_FRAC_BITS + 1;
	localparam int PROD_W = DIST_W + TW;
	localparam int FULL_W = PROD_W + CX_W;
	localparam int SHIFT  = DIST_FRAC + TRIG_FRAC_BITS;
	localparam int RP_W   = SCALED_W + RECIP_W;
	localparam int QR_W   = SCALED_W + RANGE_W;

	logic [PROD_W-1:0]   prod_s2;
	logic                neg_s2;
	logic [FULL_W-1:0]   full;
	logic [SCALED_W-1:0] scaled_s3;
	logic                neg_s3;
	logic [RP_W-1:0]     rprod;
	logic [SCALED_W-1:0] scaled_s4;
	logic [SCALED_W-1:0] q0_s4;
	logic                neg_s4;
	logic [QR_W-1:0]     qr;
	logic [QR_W-1:0]     rem;
	logic [SCALED_W-1:0] q_s5;
	logic                neg_s5;
	logic [V_W-1:0]      base;
	logic [V_W-1:0]      v;

	// Stage 2: distance times the magnitude of sine or cosine.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= PROD_W'(dist_s1) * PROD_W'(mag_s1);
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: scale by the centre coordinate and drop the fraction bits.
	assign full = FULL_W'(prod_s2) * FULL_W'(centre);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			scaled_s3 <= full[SHIFT +: SCALED_W];
			neg_s3 <= neg_s2;
		end
	end

	// Stage 4: quotient estimate from the reciprocal of the range; it is
	// either exact or one short.
	assign rprod = RP_W'(scaled_s3) * RP_W'(recip(range));

	always_ff @(posedge clk) begin
		if (en.s4) begin
			q0_s4 <= rprod[RECIP_SHIFT +: SCALED_W];
			scaled_s4 <= scaled_s3;
			neg_s4 <= neg_s3;
		end
	end

	// Stage 5: correct the estimate when the remainder reaches the range.
	assign qr = QR_W'(q0_s4) * QR_W'(range);
	assign rem = QR_W'(scaled_s4) - qr;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			q_s5 <= (rem >= QR_W'(range)) ? q0_s4 + SCALED_W'(1) : q0_s4;
			neg_s5 <= neg_s4;
		end
	end

	// Stage 6: offset from the centre minus one and clamp negative results at zero.
	assign base = V_W'(centre) - V_W'(1);
	assign v = neg_s5 ? base - V_W'(q_s5) : base + V_W'(q_s5);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			coord_s6 <= v[V_W-1] ? '0 : v[COORD_W-1:0];
		end
	end

endmodule

// ----- design/polar_to_screen_point_top.sv -----
// A word accepted at the input passes through the stage registers s1 to s6
// and shows on out_data from s6; one word per cycle in steady state while the
// output is not stalled.
// The six stages are the angle table lookup, two scaling multipliers and a
// reciprocal divide with its correction and final offset.
// Reset clears all stage valid bits and loads the default center and range.
module polar_to_screen_point_top #(
	parameter int TRIG_FRAC_BITS = p2s_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  p2s_pkg::in_word_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output p2s_pkg::out_word_t             out_data,
	input  logic                           cfg_we,
	input  logic [p2s_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [p2s_pkg::CFG_W-1:0]      cfg_wdata
);
	import p2s_pkg::*;

	localparam int TW = TRIG_FRAC_BITS + 1;

	logic [CX_W-1:0]    center_x_q;
	logic [CY_W-1:0]    center_y_q;
	logic [RANGE_W-1:0] full_range_q;
	logic [RANGE_W-1:0] range_eff;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en_s1;
	stage_en_t en;

	logic [ANG_W-1:0] ang_mod;
	logic [ANG_W-1:0] rem_full;
	logic [1:0]       quad;
	logic [TW-1:0]    sin_val;
	logic [TW-1:0]    cos_val;

	logic [DIST_W-1:0] dist_s1;
	logic [TW-1:0]     mag_x_s1;
	logic [TW-1:0]     mag_y_s1;
	logic              neg_x_s1;
	logic              neg_y_s1;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	logic [COORD_W-1:0] x_s6;
	logic [COORD_W-1:0] y_s6;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			full_range_q <= FULL_RANGE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CENTER_X:   center_x_q <= cfg_wdata[CX_W-1:0];
				CFG_CENTER_Y:   center_y_q <= cfg_wdata[CY_W-1:0];
				CFG_FULL_RANGE: full_range_q <= cfg_wdata[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// A range of zero divides as one.
	assign range_eff = (full_range_q == '0) ? RANGE_W'(1) : full_range_q;

	// Stage enables: a stage loads when it is empty or its word moves on.
	assign en.s6 = !valid_s6 || !out_stall;
	assign en.s5 = !valid_s5 || en.s6;
	assign en.s4 = !valid_s4 || en.s5;
	assign en.s3 = !valid_s3 || en.s4;
	assign en.s2 = !valid_s2 || en.s3;
	assign en_s1 = !valid_s1 || en.s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
		end
	end

	// Fold the angle into one turn, then split into quadrant and remainder.
	assign ang_mod = (in_data.angle_deg >= FULL_TURN) ?
		in_data.angle_deg - FULL_TURN : in_data.angle_deg;

	always_comb begin
		priority if (ang_mod < DEG_90) begin
			quad = QUAD_I;
			rem_full = ang_mod;
		end else if (ang_mod < DEG_180) begin
			quad = QUAD_II;
			rem_full = ang_mod - DEG_90;
		end else if (ang_mod < DEG_270) begin
			quad = QUAD_III;
			rem_full = ang_mod - DEG_180;
		end else begin
			quad = QUAD_IV;
			rem_full = ang_mod - DEG_270;
		end
	end

	p2s_trig #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_trig (
		.rem_deg(rem_full[REM_W-1:0]),
		.sin_val(sin_val),
		.cos_val(cos_val)
	);

	// Stage 1: magnitude and sign of cosine (x) and sine (y) per quadrant.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			dist_s1 <= in_data.distance;
			last_s1 <= in_data.last_point;
			unique case (quad)
				QUAD_I: begin
					mag_x_s1 <= cos_val;
					neg_x_s1 <= 1'b0;
					mag_y_s1 <= sin_val;
					neg_y_s1 <= 1'b0;
				end
				QUAD_II: begin
					mag_x_s1 <= sin_val;
					neg_x_s1 <= 1'b1;
					mag_y_s1 <= cos_val;
					neg_y_s1 <= 1'b0;
				end
				QUAD_III: begin
					mag_x_s1 <= cos_val;
					neg_x_s1 <= 1'b1;
					mag_y_s1 <= sin_val;
					neg_y_s1 <= 1'b1;
				end
				default: begin
					mag_x_s1 <= sin_val;
					neg_x_s1 <= 1'b0;
					mag_y_s1 <= cos_val;
					neg_y_s1 <= 1'b1;
				end
			endcase
		end
	end

	// The last-point flag rides along with the word.
	always_ff @(posedge clk) begin
		if (en.s2) last_s2 <= last_s1;
		if (en.s3) last_s3 <= last_s2;
		if (en.s4) last_s4 <= last_s3;
		if (en.s5) last_s5 <= last_s4;
		if (en.s6) last_s6 <= last_s5;
	end

	p2s_axis #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_axis_x (
		.clk(clk),
		.en(en),
		.dist_s1(dist_s1),
		.mag_s1(mag_x_s1),
		.neg_s1(neg_x_s1),
		.centre(center_x_q),
		.range(range_eff),
		.coord_s6(x_s6)
	);

	p2s_axis #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_axis_y (
		.clk(clk),
		.en(en),
		.dist_s1(dist_s1),
		.mag_s1(mag_y_s1),
		.neg_s1(neg_y_s1),
		.centre(CX_W'(center_y_q)),
		.range(range_eff),
		.coord_s6(y_s6)
	);

	// Output word.
	assign out_valid = valid_s6;
	assign out_data.x_coord = x_s6;
	assign out_data.y_coord = y_s6;
	assign out_data.last_out = last_s6;

endmodule

// ----- design/p2s_checker.sv -----
module p2s_assertions (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input p2s_pkg::in_word_t   in_data,
	input logic                out_valid,
	input logic                out_stall,
	input p2s_pkg::out_word_t  out_data
);
	import p2s_pkg::*;

	// A stalled result word stays and holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

	// With the output slot empty the whole pipeline is free to take a word.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is empty");

	// An accepted word reaches the output when the output does not stall while it moves through the stages.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
		##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("accepted word did not reach the output");

	// Coordinates never exceed the largest center minus one plus the largest quotient.
	a_coord_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.x_coord <= 12'd2173 && out_data.y_coord <= 12'd2109)
		else $error("coordinate out of reachable range");

	// A waiting input word carries a known last-point flag.
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> !$isunknown(in_data.last_point) || !in_valid)
		else $error("input word unknown while stalled");

endmodule

bind polar_to_screen_point_top p2s_assertions u_p2s_assertions (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
